[rtl/fla_pkg.sv]
// Shared codes for the free-list block allocator.
// Holds request/status/fit-mode codes and fixed field widths; no dependencies.
package fla_pkg;

   localparam int SIZE_W  = 16;
   localparam int NEED_W  = 17;
   localparam int HDR_W   = 7;
   localparam int MODE_W  = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 7;

   // request kinds
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   // response status
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_NULL    = 2'd1;
   localparam logic [1:0] STAT_OOM     = 2'd2;
   localparam logic [1:0] STAT_BADFREE = 2'd3;

   // search policy
   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_BEST  = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;
   localparam logic [1:0] FIT_NEXT  = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FIT_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER   = 2'd1;

   localparam logic [HDR_W-1:0] HDR_RESET = 7'd24;

endpackage

[rtl/free_list_block_allocator.sv]
// Free-list block allocator: address-ordered block table in one synchronous RAM; uses fla_pkg.
// Each table entry scanned is read, then checked; each entry moved on a split or a
//   coalesce is read, then written; decision and wrap-up states follow.
// One request at a time: new requests are stalled until the result is handed on; worst
//   case is a full best-fit scan followed by a split that shifts nearly every entry up by one.
// Reset: table count, heap top and rover clear; table RAM contents are not cleared.
module free_list_block_allocator #(
   parameter int MAX_BLOCKS = 64,
   parameter int HEAP_BYTES = 65536
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_type,
   input  logic [fla_pkg::SIZE_W-1:0]        req_request_size,
   input  logic [fla_pkg::SIZE_W-1:0]        req_data_addr,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_status,
   output logic [fla_pkg::SIZE_W-1:0]        rsp_result_addr,
   output logic                              rsp_reused,
   output logic                              rsp_did_split,
   output logic [1:0]                        rsp_merges,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [fla_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fla_pkg::CSR_DAT_W-1:0]     csr_data
);

   localparam int IW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int HAW = $clog2(HEAP_BYTES) + 1;
   localparam int AW  = (HAW > 17) ? HAW : 17;
   localparam int LW  = AW + 1;

   typedef struct packed {
      logic [AW-1:0] start;
      logic [LW-1:0] len;
      logic          free;
   } entry_type;

   localparam logic [4:0] ST_IDLE = 5'd0,  ST_SRD  = 5'd1,  ST_SEV  = 5'd2,
                          ST_ADEC = 5'd3,  ST_SPRD = 5'd4,  ST_SPWR = 5'd5,
                          ST_SPW1 = 5'd6,  ST_SPW0 = 5'd7,  ST_FDEC = 5'd8,
                          ST_NRD  = 5'd9,  ST_NEV  = 5'd10, ST_LRD  = 5'd11,
                          ST_LEV  = 5'd12, ST_MWR  = 5'd13, ST_DRD  = 5'd14,
                          ST_DWR  = 5'd15, ST_DONE = 5'd16;

   localparam logic [IW:0] MAX_CNT = (IW+1)'(MAX_BLOCKS);
   localparam logic [LW-1:0] HEAP_LIM = LW'(HEAP_BYTES);

   // table RAM
   entry_type mem [MAX_BLOCKS];
   entry_type rd_ff;
   logic          rd_en;
   logic [IW-1:0] rd_addr;
   logic          we;
   logic [IW-1:0] wa;
   entry_type     wd;

   logic [4:0]    state_ff, state_in;
   logic [1:0]    fit_ff, fit_in;
   logic [6:0]    hdr_ff, hdr_in;
   logic          op_ff, op_in;
   logic [16:0]   need_ff, need_in;
   logic [15:0]   da_ff, da_in;
   logic [IW:0]   cnt_ff, cnt_in;
   logic [AW-1:0] top_ff, top_in;
   logic [IW-1:0] rov_ff, rov_in;
   logic          rovv_ff, rovv_in;
   logic [IW:0]   it_ff, it_in;
   logic [IW-1:0] k_ff, k_in;
   logic          found_ff, found_in;
   logic          any_ff, any_in;
   logic [IW-1:0] pick_ff, pick_in;
   logic [AW-1:0] pst_ff, pst_in;
   logic [LW-1:0] plen_ff, plen_in;
   logic          split_ff, split_in;
   logic [IW:0]   src_ff, src_in;
   logic [IW:0]   dst_ff, dst_in;
   logic          rfree_ff, rfree_in;
   logic [LW-1:0] rlen_ff, rlen_in;
   logic          lfree_ff, lfree_in;
   logic [AW-1:0] lst_ff, lst_in;
   logic [LW-1:0] llen_ff, llen_in;
   logic [1:0]    dd_ff, dd_in;
   logic [1:0]    rs_ff, rs_in;
   logic [15:0]   ra_ff, ra_in;
   logic          ru_ff, ru_in;
   logic          rp_ff, rp_in;
   logic [1:0]    rm_ff, rm_in;
   logic          ov_ff, ov_in;
   logic [1:0]    os_ff, os_in;
   logic [15:0]   oa_ff, oa_in;
   logic          ou_ff, ou_in;
   logic          op2_ff, op2_in;
   logic [1:0]    om_ff, om_in;

   logic [LW-1:0] hdr_x, need_x, sum_a;
   logic [IW:0]   pick_x;
   logic [IW-1:0] k_nx, rov_t;
   logic          match, better;
   logic [16:0]   need_req;
   logic [IW-1:0] w_idx;

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = ov_ff;
   assign rsp_status = os_ff;
   assign rsp_result_addr = oa_ff;
   assign rsp_reused = ou_ff;
   assign rsp_did_split = op2_ff;
   assign rsp_merges = om_ff;

   assign hdr_x  = {{(LW-7){1'b0}}, hdr_ff};
   assign need_x = {{(LW-17){1'b0}}, need_ff};
   assign pick_x = {1'b0, pick_ff};
   assign k_nx   = (({1'b0, k_ff} + 1'b1) == cnt_ff) ? '0 : k_ff + 1'b1;
   assign sum_a  = {1'b0, rd_ff.start} + hdr_x;
   assign need_req = ({1'b0, req_request_size} + 17'd3) & ~17'd3;
   assign w_idx  = lfree_ff ? pick_ff - 1'b1 : pick_ff;

   // RAM ports
   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      if (rd_en) rd_ff <= mem[rd_addr];
   end

   always_comb begin
      state_in = state_ff; fit_in = fit_ff; hdr_in = hdr_ff; op_in = op_ff;
      need_in = need_ff; da_in = da_ff; cnt_in = cnt_ff; top_in = top_ff;
      rov_in = rov_ff; rovv_in = rovv_ff; it_in = it_ff; k_in = k_ff;
      found_in = found_ff; any_in = any_ff; pick_in = pick_ff; pst_in = pst_ff;
      plen_in = plen_ff; split_in = split_ff; src_in = src_ff; dst_in = dst_ff;
      rfree_in = rfree_ff; rlen_in = rlen_ff; lfree_in = lfree_ff; lst_in = lst_ff;
      llen_in = llen_ff; dd_in = dd_ff; rs_in = rs_ff; ra_in = ra_ff; ru_in = ru_ff;
      rp_in = rp_ff; rm_in = rm_ff;
      ov_in = ov_ff & rsp_stall; os_in = os_ff; oa_in = oa_ff; ou_in = ou_ff;
      op2_in = op2_ff; om_in = om_ff;
      rd_en = 1'b0; rd_addr = k_ff; we = 1'b0; wa = pick_ff; wd = rd_ff;
      match = 1'b0; better = 1'b0; rov_t = rov_ff;

      // register writes
      if (csr_valid) begin
         case (csr_index)
            fla_pkg::CSR_FIT_MODE: fit_in = csr_data[1:0];
            fla_pkg::CSR_HEADER:   hdr_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in = req_type; need_in = need_req; da_in = req_data_addr;
               it_in = '0; found_in = 1'b0; any_in = 1'b0; split_in = 1'b0;
               rfree_in = 1'b0; lfree_in = 1'b0; dd_in = '0;
               rs_in = fla_pkg::STAT_OK; ra_in = '0; ru_in = 1'b0; rp_in = 1'b0;
               rm_in = '0;
               k_in = '0;
               if (req_type == fla_pkg::REQ_ALLOC && fit_ff == fla_pkg::FIT_NEXT &&
                   rovv_ff && ({1'b0, rov_ff} < cnt_ff))
                  k_in = rov_ff;
               if (req_type == fla_pkg::REQ_ALLOC && req_request_size == '0) begin
                  rs_in = fla_pkg::STAT_NULL;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SRD;
               end
            end
         end
         // table scan: issue read
         ST_SRD: begin
            if (it_ff == cnt_ff) begin
               if (op_ff == fla_pkg::REQ_ALLOC) begin
                  state_in = ST_ADEC;
               end else begin
                  rs_in = (da_ff == '0 && !any_ff) ? fla_pkg::STAT_OK
                                                   : fla_pkg::STAT_BADFREE;
                  state_in = ST_DONE;
               end
            end else begin
               rd_en = 1'b1; rd_addr = k_ff;
               state_in = ST_SEV;
            end
         end
         // table scan: check entry
         ST_SEV: begin
            it_in = it_ff + 1'b1;
            k_in = k_nx;
            state_in = ST_SRD;
            if (op_ff == fla_pkg::REQ_ALLOC) begin
               match = rd_ff.free && (rd_ff.len >= need_x);
               better = !found_ff ||
                        (fit_ff == fla_pkg::FIT_BEST && rd_ff.len < plen_ff) ||
                        (fit_ff == fla_pkg::FIT_WORST && rd_ff.len > plen_ff);
               if (match && better) begin
                  found_in = 1'b1; pick_in = k_ff;
                  pst_in = rd_ff.start; plen_in = rd_ff.len;
                  if (fit_ff == fla_pkg::FIT_FIRST || fit_ff == fla_pkg::FIT_NEXT)
                     state_in = ST_ADEC;
                  if (fit_ff == fla_pkg::FIT_NEXT) begin
                     rov_in = k_ff; rovv_in = 1'b1;
                  end
               end
            end else begin
               match = (sum_a[15:0] == da_ff);
               if (match) any_in = 1'b1;
               if (match && !rd_ff.free) begin
                  found_in = 1'b1; pick_in = k_ff;
                  pst_in = rd_ff.start; plen_in = rd_ff.len;
                  state_in = ST_FDEC;
               end
            end
         end
         // allocate decision: reuse, split, grow or report out of memory
         ST_ADEC: begin
            if (found_ff) begin
               ru_in = 1'b1;
               ra_in = 16'(pst_ff + AW'(hdr_ff));
               if (plen_ff > need_x + hdr_x && cnt_ff < MAX_CNT) begin
                  split_in = 1'b1; rp_in = 1'b1;
                  if (rov_ff > pick_ff) rov_in = rov_ff + 1'b1;
                  src_in = cnt_ff - 1'b1;
                  state_in = ((cnt_ff - 1'b1) > pick_x) ? ST_SPRD : ST_SPW1;
               end else begin
                  state_in = ST_SPW0;
               end
            end else begin
               if (fit_ff == fla_pkg::FIT_NEXT) rovv_in = 1'b0;
               if (cnt_ff >= MAX_CNT ||
                   ({1'b0, top_ff} + hdr_x + need_x) > HEAP_LIM) begin
                  rs_in = fla_pkg::STAT_OOM;
               end else begin
                  we = 1'b1; wa = cnt_ff[IW-1:0];
                  wd.start = top_ff; wd.len = need_x; wd.free = 1'b0;
                  cnt_in = cnt_ff + 1'b1;
                  top_in = AW'({1'b0, top_ff} + hdr_x + need_x);
                  if (fit_ff == fla_pkg::FIT_NEXT || !rovv_ff) begin
                     rov_in = cnt_ff[IW-1:0]; rovv_in = 1'b1;
                  end
                  ra_in = 16'(top_ff + AW'(hdr_ff));
               end
               state_in = ST_DONE;
            end
         end
         // split: move entries up by one
         ST_SPRD: begin
            rd_en = 1'b1; rd_addr = src_ff[IW-1:0];
            state_in = ST_SPWR;
         end
         ST_SPWR: begin
            we = 1'b1; wa = IW'(src_ff + 1'b1); wd = rd_ff;
            src_in = src_ff - 1'b1;
            state_in = ((src_ff - 1'b1) > pick_x) ? ST_SPRD : ST_SPW1;
         end
         ST_SPW1: begin
            we = 1'b1; wa = IW'(pick_x + 1'b1);
            wd.start = AW'({1'b0, pst_ff} + hdr_x + need_x);
            wd.len = plen_ff - hdr_x - need_x;
            wd.free = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            state_in = ST_SPW0;
         end
         ST_SPW0: begin
            we = 1'b1; wa = pick_ff;
            wd.start = pst_ff; wd.len = split_ff ? need_x : plen_ff; wd.free = 1'b0;
            state_in = ST_DONE;
         end
         // free: look at neighbors
         ST_FDEC: begin
            if ((pick_x + 1'b1) < cnt_ff) state_in = ST_NRD;
            else if (pick_ff != '0) state_in = ST_LRD;
            else state_in = ST_MWR;
         end
         ST_NRD: begin
            rd_en = 1'b1; rd_addr = IW'(pick_x + 1'b1);
            state_in = ST_NEV;
         end
         ST_NEV: begin
            rfree_in = rd_ff.free; rlen_in = rd_ff.len;
            state_in = (pick_ff != '0) ? ST_LRD : ST_MWR;
         end
         ST_LRD: begin
            rd_en = 1'b1; rd_addr = pick_ff - 1'b1;
            state_in = ST_LEV;
         end
         ST_LEV: begin
            lfree_in = rd_ff.free; lst_in = rd_ff.start; llen_in = rd_ff.len;
            state_in = ST_MWR;
         end
         // write coalesced block, then close the gap
         ST_MWR: begin
            we = 1'b1; wa = w_idx;
            wd.start = lfree_ff ? lst_ff : pst_ff;
            wd.len = (lfree_ff ? llen_ff + hdr_x : '0) + plen_ff +
                     (rfree_ff ? hdr_x + rlen_ff : '0);
            wd.free = 1'b1;
            dd_in = {1'b0, rfree_ff} + {1'b0, lfree_ff};
            rm_in = {1'b0, rfree_ff} + {1'b0, lfree_ff};
            if (rfree_ff && ({1'b0, rov_t} >= pick_x + 1'b1) && rov_t != '0)
               rov_t = rov_t - 1'b1;
            if (lfree_ff && (rov_t >= pick_ff) && rov_t != '0)
               rov_t = rov_t - 1'b1;
            rov_in = rov_t;
            dst_in = {1'b0, w_idx} + 1'b1;
            src_in = {1'b0, w_idx} + 1'b1 + {{(IW-1){1'b0}}, rfree_ff}
                     + {{(IW-1){1'b0}}, lfree_ff};
            state_in = (rfree_ff || lfree_ff) ? ST_DRD : ST_DONE;
         end
         ST_DRD: begin
            if (src_ff >= cnt_ff) begin
               cnt_in = cnt_ff - {{(IW-1){1'b0}}, dd_ff};
               state_in = ST_DONE;
            end else begin
               rd_en = 1'b1; rd_addr = src_ff[IW-1:0];
               state_in = ST_DWR;
            end
         end
         ST_DWR: begin
            we = 1'b1; wa = dst_ff[IW-1:0]; wd = rd_ff;
            src_in = src_ff + 1'b1; dst_in = dst_ff + 1'b1;
            state_in = ST_DRD;
         end
         // hand result to output register
         ST_DONE: begin
            if (!ov_ff || !rsp_stall) begin
               ov_in = 1'b1; os_in = rs_ff; oa_in = ra_ff; ou_in = ru_ff;
               op2_in = rp_ff; om_in = rm_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fit_ff   <= fla_pkg::FIT_FIRST;
         hdr_ff   <= fla_pkg::HDR_RESET;
         cnt_ff   <= '0;
         top_ff   <= '0;
         rov_ff   <= '0;
         rovv_ff  <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         fit_ff   <= fit_in;
         hdr_ff   <= hdr_in;
         cnt_ff   <= cnt_in;
         top_ff   <= top_in;
         rov_ff   <= rov_in;
         rovv_ff  <= rovv_in;
         ov_ff    <= ov_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      op_ff <= op_in; need_ff <= need_in; da_ff <= da_in;
      it_ff <= it_in; k_ff <= k_in; found_ff <= found_in; any_ff <= any_in;
      pick_ff <= pick_in; pst_ff <= pst_in; plen_ff <= plen_in;
      split_ff <= split_in; src_ff <= src_in; dst_ff <= dst_in;
      rfree_ff <= rfree_in; rlen_ff <= rlen_in; lfree_ff <= lfree_in;
      lst_ff <= lst_in; llen_ff <= llen_in; dd_ff <= dd_in;
      rs_ff <= rs_in; ra_ff <= ra_in; ru_ff <= ru_in; rp_ff <= rp_in; rm_ff <= rm_in;
      os_ff <= os_in; oa_ff <= oa_in; ou_ff <= ou_in; op2_ff <= op2_in; om_ff <= om_in;
   end

endmodule

[rtl/fla_checker.sv]
// Port-level checks for the free-list block allocator, bound to the top level.
// Depends on fla_pkg and free_list_block_allocator.
module fla_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [15:0] rsp_result_addr,
   input logic        rsp_reused,
   input logic        rsp_did_split,
   input logic [1:0]  rsp_merges
);

   // stalled beat holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_result_addr))
      else $error("stalled response changed");

   // failed or null requests return no address
   a_noaddr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != fla_pkg::STAT_OK |-> rsp_result_addr == '0
         && !rsp_reused && rsp_merges == '0)
      else $error("non-ok response carries data");

   // split only on reuse
   a_split: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_did_split |-> rsp_reused)
      else $error("split without reuse");

   // coalescing only on a free, never with an address
   a_merge: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_merges != '0 |-> rsp_result_addr == '0 && !rsp_reused
         && rsp_merges != 2'd3)
      else $error("bad merge report");

endmodule

bind free_list_block_allocator fla_checker u_fla_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_status(rsp_status), .rsp_result_addr(rsp_result_addr),
   .rsp_reused(rsp_reused), .rsp_did_split(rsp_did_split), .rsp_merges(rsp_merges)
);

[dv/free_list_block_allocator_test.sv]
// Self-checking testbench for the free-list block allocator.
// Directed table then random allocate/free traffic, checked against an in-bench predictor.
// Depends on fla_pkg and rtl/free_list_block_allocator.sv.
`timescale 1ns / 100ps

module free_list_block_allocator_test;

   localparam int MAXB = 64;
   localparam int HEAP = 65536;
   localparam int N_RANDOM = 1930;
   localparam longint CYCLE_LIMIT = 4000000;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] addr;
      logic        reused;
      logic        did_split;
      logic [1:0]  merges;
   } alloc_result_type;

   typedef struct {
      logic        kind;
      logic [15:0] size;
      logic [15:0] daddr;
      bit          typed;
      logic [1:0]  exp_status;
      logic [15:0] exp_addr;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, req_stall;
   logic req_type = 1'b0;
   logic [15:0] req_request_size = '0, req_data_addr = '0;
   logic rsp_valid, rsp_stall = 1'b0;
   logic [1:0] rsp_status, rsp_merges;
   logic [15:0] rsp_result_addr;
   logic rsp_reused, rsp_did_split;
   logic csr_valid = 1'b0, csr_ready;
   logic [fla_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [fla_pkg::CSR_DAT_W-1:0] csr_data = '0;

   free_list_block_allocator DUT (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state
   logic [16:0] blk_start [MAXB];
   logic [16:0] blk_len [MAXB];
   bit          blk_free [MAXB];
   int unsigned blk_count, rover;
   logic [16:0] heap_top;
   bit          rover_ok;
   logic [1:0]  fit_sel;
   logic [6:0]  hdr_len;

   alloc_result_type pending_results[$];
   logic [15:0]   live_addrs[$];
   bit failed = 1'b0;
   int send_idle_pct = 0, recv_stall_pct = 0;
   bit hold_recv = 1'b0;
   longint cycles = 0;

   function automatic void remove_entry(int unsigned j);
      for (int unsigned i = j; i + 1 < blk_count; i++) begin
         blk_start[i] = blk_start[i+1];
         blk_len[i] = blk_len[i+1];
         blk_free[i] = blk_free[i+1];
      end
      blk_count--;
      if (rover >= j && rover > 0) rover--;
   endfunction

   function automatic int find_fit(logic [16:0] need);
      int pick;
      int unsigned s, k;
      pick = -1;
      if (fit_sel == fla_pkg::FIT_NEXT) begin
         s = (rover_ok && rover < blk_count) ? rover : 0;
         for (int unsigned i = 0; i < blk_count; i++) begin
            k = (s + i) % blk_count;
            if (blk_free[k] && blk_len[k] >= need) begin
               rover = k;
               rover_ok = 1'b1;
               return int'(k);
            end
         end
         rover_ok = 1'b0;
         return -1;
      end
      for (int i = 0; i < blk_count; i++) begin
         if (!blk_free[i] || blk_len[i] < need) continue;
         if (pick < 0) begin
            pick = i;
            if (fit_sel == fla_pkg::FIT_FIRST) return pick;
         end else if (fit_sel == fla_pkg::FIT_BEST && blk_len[i] < blk_len[pick]) begin
            pick = i;
         end else if (fit_sel == fla_pkg::FIT_WORST && blk_len[i] > blk_len[pick]) begin
            pick = i;
         end
      end
      return pick;
   endfunction

   function automatic alloc_result_type predict_request(logic kind, logic [15:0] size,
                                                        logic [15:0] daddr);
      alloc_result_type r;
      logic [16:0] need;
      int f, hit;
      int unsigned b;
      bit any;
      r = '0;
      if (kind == fla_pkg::REQ_ALLOC) begin
         if (size == 0) begin
            r.status = fla_pkg::STAT_NULL;
         end else begin
            need = ({1'b0, size} + 17'd3) & ~17'd3;
            f = find_fit(need);
            if (f >= 0) begin
               b = unsigned'(f);
               r.reused = 1'b1;
               if (blk_len[b] > need + hdr_len && blk_count < MAXB) begin
                  for (int unsigned i = blk_count; i > b + 1; i--) begin
                     blk_start[i] = blk_start[i-1];
                     blk_len[i] = blk_len[i-1];
                     blk_free[i] = blk_free[i-1];
                  end
                  blk_start[b+1] = blk_start[b] + hdr_len + need;
                  blk_len[b+1] = blk_len[b] - hdr_len - need;
                  blk_free[b+1] = 1'b1;
                  blk_len[b] = need;
                  blk_count++;
                  if (rover > b) rover++;
                  r.did_split = 1'b1;
               end
               blk_free[b] = 1'b0;
               r.addr = 16'(blk_start[b] + hdr_len);
            end else if (blk_count >= MAXB || int'(heap_top) + hdr_len + need > HEAP) begin
               r.status = fla_pkg::STAT_OOM;
            end else begin
               b = blk_count;
               blk_start[b] = heap_top;
               blk_len[b] = need;
               blk_free[b] = 1'b0;
               blk_count++;
               heap_top = heap_top + hdr_len + need;
               if (!rover_ok) begin
                  rover = b;
                  rover_ok = 1'b1;
               end
               r.addr = 16'(blk_start[b] + hdr_len);
            end
         end
      end else begin
         hit = -1;
         any = 1'b0;
         for (int i = 0; i < blk_count; i++) begin
            if (16'(blk_start[i] + hdr_len) == daddr) begin
               any = 1'b1;
               if (!blk_free[i]) begin
                  hit = i;
                  break;
               end
            end
         end
         if (hit < 0) begin
            r.status = (daddr == 0 && !any) ? fla_pkg::STAT_OK : fla_pkg::STAT_BADFREE;
         end else begin
            b = unsigned'(hit);
            blk_free[b] = 1'b1;
            if (b + 1 < blk_count && blk_free[b+1]) begin
               blk_len[b] = blk_len[b] + hdr_len + blk_len[b+1];
               remove_entry(b + 1);
               r.merges++;
            end
            if (b > 0 && blk_free[b-1]) begin
               blk_len[b-1] = blk_len[b-1] + hdr_len + blk_len[b];
               remove_entry(b);
               r.merges++;
            end
         end
      end
      return r;
   endfunction

   // cycle counter and timeout
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("free_list_block_allocator test failed");
         $finish;
      end
   end

   // receiver: random stall, compare each accepted beat
   always @(posedge clock) begin
      alloc_result_type exp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result beat, status %0d", rsp_status);
            failed = 1'b1;
         end else begin
            exp = pending_results.pop_front();
            if (rsp_status !== exp.status) begin
               $error("status: expected %0d, got %0d", exp.status, rsp_status);
               failed = 1'b1;
            end
            if (rsp_result_addr !== exp.addr) begin
               $error("result_addr: expected %0h, got %0h", exp.addr, rsp_result_addr);
               failed = 1'b1;
            end
            if (rsp_reused !== exp.reused) begin
               $error("reused: expected %0d, got %0d", exp.reused, rsp_reused);
               failed = 1'b1;
            end
            if (rsp_did_split !== exp.did_split) begin
               $error("did_split: expected %0d, got %0d", exp.did_split, rsp_did_split);
               failed = 1'b1;
            end
            if (rsp_merges !== exp.merges) begin
               $error("merges: expected %0d, got %0d", exp.merges, rsp_merges);
               failed = 1'b1;
            end
         end
      end
      rsp_stall <= hold_recv || ($urandom_range(99) < recv_stall_pct);
   end

   // long receiver hold-off, counted here
   task automatic hold_receiver(int n);
      hold_recv = 1'b1;
      repeat (n) @(posedge clock);
      hold_recv = 1'b0;
   endtask

   // one register beat; valid drops for a cycle before the next write
   task automatic write_reg(logic [fla_pkg::CSR_IDX_W-1:0] idx,
                            logic [fla_pkg::CSR_DAT_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == fla_pkg::CSR_FIT_MODE) fit_sel = val[1:0];
      else hdr_len = val;
      @(posedge clock);
   endtask

   // one beat; valid stays up until the next beat, an idle cycle or a drain
   task automatic send_request(logic kind, logic [15:0] size, logic [15:0] daddr,
                               bit typed = 0, logic [1:0] es = 0, logic [15:0] ea = 0);
      alloc_result_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_request_size <= size;
      req_data_addr <= daddr;
      do @(posedge clock); while (req_stall);
      r = predict_request(kind, size, daddr);
      if (typed && (r.status != es || r.addr != ea)) begin
         $error("typed row: expected %0d/%0h, predictor %0d/%0h", es, ea, r.status, r.addr);
         failed = 1'b1;
      end
      pending_results.push_back(r);
      if (kind == fla_pkg::REQ_ALLOC && r.status == fla_pkg::STAT_OK)
         live_addrs.push_back(r.addr);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic random_item(int alloc_pct, int maxsz);
      int k;
      logic [15:0] a;
      if ($urandom_range(99) < alloc_pct || live_addrs.size() == 0) begin
         send_request(fla_pkg::REQ_ALLOC,
                      (maxsz > 0) ? 16'($urandom_range(maxsz)) : 16'($urandom),
                      16'($urandom));
      end else if ($urandom_range(9) == 0) begin
         // noise: a random address or zero
         a = ($urandom_range(1)) ? 16'($urandom) : 16'h0;
         send_request(fla_pkg::REQ_FREE, 16'($urandom), a);
      end else begin
         k = $urandom_range(live_addrs.size() - 1);
         a = live_addrs[k];
         live_addrs.delete(k);
         send_request(fla_pkg::REQ_FREE, 16'($urandom), a);
      end
   endtask

   stim_row_type dir_rows[$];

   initial begin
      int mode_vals[4];
      logic [6:0] hdr_vals[5];
      stim_row_type row;
      hdr_vals = '{7'd4, 7'd64, 7'd24, 7'd127, 7'd0};
      mode_vals = '{fla_pkg::FIT_FIRST, fla_pkg::FIT_BEST, fla_pkg::FIT_WORST,
                    fla_pkg::FIT_NEXT};

      blk_count = 0; heap_top = 0; rover = 0; rover_ok = 0;
      fit_sel = fla_pkg::FIT_FIRST; hdr_len = fla_pkg::HDR_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table: after reset, header 24, first fit
      dir_rows = '{
         '{fla_pkg::REQ_ALLOC, 16'd0,     16'h0,    1, fla_pkg::STAT_NULL,    16'h0},
         '{fla_pkg::REQ_FREE,  16'h0,     16'h0,    1, fla_pkg::STAT_OK,      16'h0},
         '{fla_pkg::REQ_FREE,  16'h0,     16'h1234, 1, fla_pkg::STAT_BADFREE, 16'h0},
         '{fla_pkg::REQ_ALLOC, 16'd1,     16'h0,    1, fla_pkg::STAT_OK,      16'd24},
         '{fla_pkg::REQ_ALLOC, 16'd100,   16'h0,    1, fla_pkg::STAT_OK,      16'd52},
         '{fla_pkg::REQ_ALLOC, 16'd4,     16'h0,    1, fla_pkg::STAT_OK,      16'd176},
         '{fla_pkg::REQ_ALLOC, 16'hFFFF,  16'h0,    1, fla_pkg::STAT_OOM,     16'h0},
         '{fla_pkg::REQ_FREE,  16'h0,     16'd52,   0, 0, 0},
         '{fla_pkg::REQ_FREE,  16'h0,     16'd52,   1, fla_pkg::STAT_BADFREE, 16'h0},
         '{fla_pkg::REQ_FREE,  16'h0,     16'd24,   0, 0, 0},
         '{fla_pkg::REQ_ALLOC, 16'd8,     16'h0,    0, 0, 0},
         '{fla_pkg::REQ_ALLOC, 16'd3,     16'h0,    0, 0, 0},
         '{fla_pkg::REQ_FREE,  16'h0,     16'd176,  0, 0, 0},
         '{fla_pkg::REQ_ALLOC, 16'd65000, 16'h0,    0, 0, 0},
         '{fla_pkg::REQ_FREE,  16'hFFFF,  16'hFFFF, 0, 0, 0},
         '{fla_pkg::REQ_ALLOC, 16'd65535, 16'hFFFF, 0, 0, 0}
      };
      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         send_request(row.kind, row.size, row.daddr, row.typed, row.exp_status, row.exp_addr);
      end
      drain();

      // random phases over register settings and idle profiles
      for (int ph = 0; ph < 10; ph++) begin
         write_reg(fla_pkg::CSR_FIT_MODE, fla_pkg::CSR_DAT_W'(mode_vals[ph % 4]));
         write_reg(fla_pkg::CSR_HEADER, hdr_vals[ph % 5]);
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
            default: begin send_idle_pct = 38; recv_stall_pct = 38; end
         endcase
         if (ph == 4) begin
            fork
               hold_receiver(600);
               for (int i = 0; i < 8; i++) random_item(60, 200);
            join
         end
         for (int i = 0; i < N_RANDOM / 10; i++) begin
            if (i == 90) begin
               // pause until everything has come back
               req_valid <= 1'b0;
               while (pending_results.size() != 0) @(posedge clock);
            end
            // mostly small sizes; a few huge ones to reach out of memory
            random_item(55, ($urandom_range(30) == 0) ? 0 : 600);
         end
         drain();
         // forget the live list; blocks left in use keep the table fragmented
         live_addrs.delete();
      end

      if (!failed && pending_results.size() == 0) begin
         $display("free_list_block_allocator test passed");
      end else begin
         $display("free_list_block_allocator test failed");
      end
      $finish;
   end

endmodule
